>>> src/xml_tag_nesting_checker_assert.svh
// assertion macros for the xml tag nesting checker
`ifndef XML_TAG_NESTING_CHECKER_ASSERT_SVH
`define XML_TAG_NESTING_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF
`define XTN_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define XTN_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);
`else
`define XTN_ASSERT(lbl, prop, msg)
`define XTN_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> src/xtn_pkg.sv
// shared types and constants for the xml tag nesting checker
`default_nettype none

package xtn_pkg;

   localparam int DEFAULT_STACK_DEPTH  = 32;
   localparam int DEFAULT_MAX_NAME_LEN = 64;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_MISMATCH   = 3'd1,
      ERR_EMPTY      = 3'd2,
      ERR_TOO_LONG   = 3'd3,
      ERR_OVERFLOW   = 3'd4,
      ERR_LT_IN_NAME = 3'd5
   } error_type;

   typedef struct packed {
      logic       still_valid;
      error_type  error_kind;
      logic [5:0] open_depth;
   } status_type;

endpackage

`default_nettype wire

>>> src/xtn_req_if.sv
// input byte channel
`default_nettype none

interface xtn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

>>> src/xtn_rsp_if.sv
// result channel
`default_nettype none

interface xtn_rsp_if;
   import xtn_pkg::*;

   logic       valid;
   logic       ready;
   logic       still_valid;
   error_type  error_kind;
   logic [5:0] open_depth;

   modport source (output valid, output still_valid, output error_kind, output open_depth,
                   input ready);
   modport sink (input valid, input still_valid, input error_kind, input open_depth,
                 output ready);
endinterface

`default_nettype wire

>>> src/xml_tag_nesting_checker.sv
// top level of the xml tag nesting checker
//
// req_bus carries one document byte per transfer, rsp_bus returns one status
// per byte: still_valid, error_kind and open_depth after that byte.
// path: a byte taken goes into the input register, then through the scanner into
// the result register, where its result holds until rsp_bus takes it.
// throughput: one byte per cycle while the receiver does not stall; the closing
// name compare reads the stored byte that the previous cycle addressed, so the
// name store read address is formed from the scanner state after each byte.
// the input register and the result register form two stages; while the
// receiver stalls, the result holds and one more byte waits in the input
// register, after which req_bus.ready drops.
// reset clears the scanner to text mode, depth zero, no error; the name
// store and length table are not cleared, only entries pushed since are read.
// errors are sticky: every later result repeats the first error seen.
`default_nettype none

module xml_tag_nesting_checker #(
   parameter int STACK_DEPTH  = xtn_pkg::DEFAULT_STACK_DEPTH,
   parameter int MAX_NAME_LEN = xtn_pkg::DEFAULT_MAX_NAME_LEN
) (
   input  wire logic  clock,
   input  wire logic  reset,
   xtn_req_if.sink    req_bus,
   xtn_rsp_if.source  rsp_bus
);
   import xtn_pkg::*;

   `include "xml_tag_nesting_checker_assert.svh"

   localparam int DW  = $clog2(STACK_DEPTH + 1);
   localparam int IW  = $clog2(MAX_NAME_LEN + 1);
   localparam int LAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SAW = (STACK_DEPTH * MAX_NAME_LEN > 1) ?
                        $clog2(STACK_DEPTH * MAX_NAME_LEN) : 1;

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            rsp_valid_ff;
   status_type      rsp_q_ff;
   logic            advance;
   status_type      status;

   logic            store_we;
   logic [SAW-1:0]  store_waddr;
   logic [7:0]      store_wdata;
   logic [SAW-1:0]  store_raddr;
   logic [7:0]      store_rd_data;
   logic            len_we;
   logic [LAW-1:0]  len_waddr;
   logic [IW-1:0]   len_wdata;
   logic [LAW-1:0]  len_raddr;
   logic [IW-1:0]   len_rd_data;

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.valid && req_bus.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.text_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_q_ff <= status;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.still_valid = rsp_q_ff.still_valid;
   assign rsp_bus.error_kind  = rsp_q_ff.error_kind;
   assign rsp_bus.open_depth  = rsp_q_ff.open_depth;

   xtn_scanner #(
      .STACK_DEPTH  (STACK_DEPTH),
      .MAX_NAME_LEN (MAX_NAME_LEN),
      .DW           (DW),
      .IW           (IW),
      .LAW          (LAW),
      .SAW          (SAW)
   ) u_scanner (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .text_byte     (in_byte_ff),
      .store_rd_data (store_rd_data),
      .len_rd_data   (len_rd_data),
      .status        (status),
      .store_we      (store_we),
      .store_waddr   (store_waddr),
      .store_wdata   (store_wdata),
      .store_raddr   (store_raddr),
      .len_we        (len_we),
      .len_waddr     (len_waddr),
      .len_wdata     (len_wdata),
      .len_raddr     (len_raddr)
   );

   xtn_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH * MAX_NAME_LEN),
      .AW    (SAW)
   ) u_name_store (
      .clock   (clock),
      .wr_en   (store_we),
      .wr_addr (store_waddr),
      .wr_data (store_wdata),
      .rd_addr (store_raddr),
      .rd_data (store_rd_data)
   );

   xtn_ram #(
      .WIDTH (IW),
      .DEPTH (STACK_DEPTH),
      .AW    (LAW)
   ) u_name_lengths (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (len_waddr),
      .wr_data (len_wdata),
      .rd_addr (len_raddr),
      .rd_data (len_rd_data)
   );

   // errors are sticky in the result stream, still_valid agrees with error_kind, and a waiting byte holds while stalled
   `XTN_ASSERT(a_error_sticky, (rsp_valid_ff && !rsp_q_ff.still_valid) |=> !rsp_q_ff.still_valid, "error state left after being raised")
   `XTN_ASSERT_NEVER(a_status_consistent, rsp_valid_ff && (rsp_q_ff.still_valid != (rsp_q_ff.error_kind == ERR_NONE)), "still_valid disagrees with error_kind")
   `XTN_ASSERT(a_input_held, (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)), "waiting byte lost while result stalled")

endmodule

`default_nettype wire

>>> src/xtn_ram.sv
// generic single write port ram with registered read
`default_nettype none

module xtn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> src/xtn_scanner.sv
// tag scanner state machine with stack control
`default_nettype none

module xtn_scanner #(
   parameter int STACK_DEPTH  = xtn_pkg::DEFAULT_STACK_DEPTH,
   parameter int MAX_NAME_LEN = xtn_pkg::DEFAULT_MAX_NAME_LEN,
   parameter int DW  = $clog2(STACK_DEPTH + 1),
   parameter int IW  = $clog2(MAX_NAME_LEN + 1),
   parameter int LAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
   parameter int SAW = (STACK_DEPTH * MAX_NAME_LEN > 1) ?
                       $clog2(STACK_DEPTH * MAX_NAME_LEN) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic [7:0]          text_byte,
   input  wire logic [7:0]          store_rd_data,
   input  wire logic [IW-1:0]       len_rd_data,
   output xtn_pkg::status_type      status,
   output logic                     store_we,
   output logic      [SAW-1:0]      store_waddr,
   output logic      [7:0]          store_wdata,
   output logic      [SAW-1:0]      store_raddr,
   output logic                     len_we,
   output logic      [LAW-1:0]      len_waddr,
   output logic      [IW-1:0]       len_wdata,
   output logic      [LAW-1:0]      len_raddr
);
   import xtn_pkg::*;

   localparam int AW = DW + IW + 1;
   localparam logic [AW-1:0] MAX_W   = AW'(MAX_NAME_LEN);
   localparam logic [IW-1:0] MAX_I   = IW'(MAX_NAME_LEN);
   localparam logic [DW-1:0] STACK_D = DW'(STACK_DEPTH);

   typedef enum logic [2:0] {
      MODE_TEXT,
      MODE_AFTER_LT,
      MODE_AFTER_SLASH,
      MODE_OPEN_NAME,
      MODE_CLOSE_NAME,
      MODE_SKIP
   } mode_type;

   mode_type        mode_ff,  mode_in;
   logic [IW-1:0]   idx_ff,   idx_in;
   logic [DW-1:0]   depth_ff, depth_in;
   logic            mis_ff,   mis_in;
   logic            valid_ff, valid_in;
   error_type       err_ff,   err_in;

   logic            take_en;
   logic            end_en;
   logic            opening;
   logic [IW-1:0]   cur;
   logic [DW-1:0]   top_row;
   logic [DW+5:0]   depth_ext;

   always_comb begin
      mode_in  = mode_ff;
      idx_in   = idx_ff;
      depth_in = depth_ff;
      mis_in   = mis_ff;
      valid_in = valid_ff;
      err_in   = err_ff;
      take_en  = 1'b0;
      end_en   = 1'b0;
      opening  = (mode_ff == MODE_OPEN_NAME) || (mode_ff == MODE_AFTER_LT);
      cur      = idx_ff;
      store_we = 1'b0;
      len_we   = 1'b0;

      if (advance && valid_ff) begin
         case (mode_ff)
            MODE_TEXT: begin
               if (text_byte == CHAR_LT) begin
                  mode_in = MODE_AFTER_LT;
               end
            end
            MODE_AFTER_LT: begin
               if (text_byte == CHAR_SLASH) begin
                  mode_in = MODE_AFTER_SLASH;
               end else begin
                  cur     = '0;
                  mis_in  = 1'b0;
                  take_en = 1'b1;
                  mode_in = MODE_OPEN_NAME;
               end
            end
            MODE_AFTER_SLASH: begin
               cur     = '0;
               mis_in  = 1'b0;
               take_en = 1'b1;
               mode_in = MODE_CLOSE_NAME;
            end
            MODE_OPEN_NAME, MODE_CLOSE_NAME: begin
               if (text_byte == CHAR_GT) begin
                  end_en  = 1'b1;
                  mode_in = MODE_TEXT;
               end else if (text_byte == CHAR_SPACE) begin
                  end_en  = 1'b1;
                  mode_in = MODE_SKIP;
               end else if (text_byte == CHAR_LT) begin
                  valid_in = 1'b0;
                  err_in   = ERR_LT_IN_NAME;
               end else begin
                  take_en = 1'b1;
               end
            end
            MODE_SKIP: begin
               if (text_byte == CHAR_GT) begin
                  mode_in = MODE_TEXT;
               end
            end
            default: begin
               mode_in = MODE_TEXT;
            end
         endcase
      end

      if (take_en) begin
         if (cur >= MAX_I) begin
            valid_in = 1'b0;
            err_in   = ERR_TOO_LONG;
         end else begin
            if (opening) begin
               store_we = (depth_ff < STACK_D);
            end else if (depth_ff != '0) begin
               if ((cur >= len_rd_data) || (store_rd_data != text_byte)) begin
                  mis_in = 1'b1;
               end
            end
            idx_in = cur + 1'b1;
         end
      end

      if (end_en) begin
         if (opening) begin
            if (depth_ff >= STACK_D) begin
               valid_in = 1'b0;
               err_in   = ERR_OVERFLOW;
            end else begin
               len_we   = 1'b1;
               depth_in = depth_ff + 1'b1;
            end
         end else begin
            if (depth_ff == '0) begin
               valid_in = 1'b0;
               err_in   = ERR_EMPTY;
            end else if (mis_ff || (idx_ff != len_rd_data)) begin
               valid_in = 1'b0;
               err_in   = ERR_MISMATCH;
            end else begin
               depth_in = depth_ff - 1'b1;
            end
         end
         idx_in = '0;
         mis_in = 1'b0;
      end
   end

   // write ports address the current top slot, read ports the slot after this byte
   assign store_waddr = SAW'(AW'(depth_ff) * MAX_W + AW'(cur));
   assign store_wdata = text_byte;
   assign len_waddr   = LAW'(depth_ff);
   assign len_wdata   = idx_ff;
   assign top_row     = depth_in - 1'b1;
   assign len_raddr   = LAW'(top_row);
   assign store_raddr = SAW'(AW'(LAW'(top_row)) * MAX_W + AW'(idx_in));

   assign depth_ext          = {6'b0, depth_in};
   assign status.still_valid = valid_in;
   assign status.error_kind  = err_in;
   assign status.open_depth  = depth_ext[5:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TEXT;
         idx_ff   <= '0;
         depth_ff <= '0;
         mis_ff   <= 1'b0;
         valid_ff <= 1'b1;
         err_ff   <= ERR_NONE;
      end else begin
         mode_ff  <= mode_in;
         idx_ff   <= idx_in;
         depth_ff <= depth_in;
         mis_ff   <= mis_in;
         valid_ff <= valid_in;
         err_ff   <= err_in;
      end
   end

endmodule

`default_nettype wire

>>> tb/xml_tag_nesting_checker_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the xml tag nesting checker with a byte-level scanner model
module xml_tag_nesting_checker_test;
   import xtn_pkg::*;

   localparam int DEPTH_MAX = DEFAULT_STACK_DEPTH;
   localparam int NAME_MAX  = DEFAULT_MAX_NAME_LEN;
   localparam int DOC_BYTES = 800;

   typedef enum logic [2:0] {
      SCAN_TEXT,
      SCAN_AFTER_LT,
      SCAN_AFTER_SLASH,
      SCAN_OPEN_NAME,
      SCAN_CLOSE_NAME,
      SCAN_SKIP
   } scan_mode_type;

   logic clock;
   logic reset = 1'b1;

   xtn_req_if req_bus ();
   xtn_rsp_if rsp_bus ();

   xml_tag_nesting_checker dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [7:0] pending_bytes[$];
   status_type status_fifo[$];
   int unsigned cycle_count = 0;
   int unsigned results_seen = 0;
   int unsigned mismatch_count = 0;

   // scanner model state
   scan_mode_type scan_state = SCAN_TEXT;
   int unsigned name_pos = 0;
   int unsigned open_count = 0;
   int unsigned deepest = 0;
   bit name_differs = 1'b0;
   bit doc_ok = 1'b1;
   error_type doc_error = ERR_NONE;
   logic [7:0] stored_names [DEPTH_MAX][NAME_MAX];
   int unsigned stored_lengths [DEPTH_MAX];

   // document generator state
   logic [7:0] gen_names [DEPTH_MAX][NAME_MAX];
   int unsigned gen_lengths [DEPTH_MAX];
   int unsigned gen_depth = 0;

   initial begin
      clock = 1'b0;
      req_bus.valid = 1'b0;
      req_bus.text_byte = 8'h00;
      rsp_bus.ready = 1'b0;
      forever #4 clock = ~clock;
   end

   function void flag_error(error_type code);
      doc_ok = 1'b0;
      doc_error = code;
   endfunction

   function void take_name_char(logic [7:0] b, bit opening);
      if (name_pos >= NAME_MAX) begin
         flag_error(ERR_TOO_LONG);
      end else begin
         if (opening) begin
            if (open_count < DEPTH_MAX)
               stored_names[open_count][name_pos] = b;
         end else if (open_count > 0) begin
            if (name_pos >= stored_lengths[open_count - 1] ||
                stored_names[open_count - 1][name_pos] != b)
               name_differs = 1'b1;
         end
         name_pos++;
      end
   endfunction

   function void finish_name(bit opening);
      if (opening) begin
         if (open_count >= DEPTH_MAX) begin
            flag_error(ERR_OVERFLOW);
         end else begin
            stored_lengths[open_count] = name_pos;
            open_count++;
         end
      end else if (open_count == 0) begin
         flag_error(ERR_EMPTY);
      end else if (name_differs || name_pos != stored_lengths[open_count - 1]) begin
         flag_error(ERR_MISMATCH);
      end else begin
         open_count--;
      end
      name_pos = 0;
      name_differs = 1'b0;
   endfunction

   function void scan_byte(logic [7:0] b);
      status_type after;
      bit opening;
      if (doc_ok) begin
         case (scan_state)
            SCAN_TEXT: begin
               if (b == CHAR_LT) scan_state = SCAN_AFTER_LT;
            end
            SCAN_AFTER_LT: begin
               if (b == CHAR_SLASH) begin
                  scan_state = SCAN_AFTER_SLASH;
               end else begin
                  name_pos = 0;
                  name_differs = 1'b0;
                  take_name_char(b, 1'b1);
                  scan_state = SCAN_OPEN_NAME;
               end
            end
            SCAN_AFTER_SLASH: begin
               name_pos = 0;
               name_differs = 1'b0;
               take_name_char(b, 1'b0);
               scan_state = SCAN_CLOSE_NAME;
            end
            SCAN_OPEN_NAME, SCAN_CLOSE_NAME: begin
               opening = (scan_state == SCAN_OPEN_NAME);
               if (b == CHAR_GT) begin
                  finish_name(opening);
                  scan_state = SCAN_TEXT;
               end else if (b == CHAR_SPACE) begin
                  finish_name(opening);
                  scan_state = SCAN_SKIP;
               end else if (b == CHAR_LT) begin
                  flag_error(ERR_LT_IN_NAME);
               end else begin
                  take_name_char(b, opening);
               end
            end
            SCAN_SKIP: begin
               if (b == CHAR_GT) scan_state = SCAN_TEXT;
            end
            default: begin
               scan_state = SCAN_TEXT;
            end
         endcase
      end
      if (open_count > deepest) deepest = open_count;
      after.still_valid = doc_ok;
      after.error_kind = doc_error;
      after.open_depth = open_count[5:0];
      status_fifo.push_back(after);
   endfunction

   function automatic bit want_gap();
      if (cycle_count >= 200 && cycle_count < 600) return 1'b0;
      return $urandom_range(0, 99) < 10;
   endfunction

   function automatic logic [7:0] name_char(bit first);
      logic [7:0] c;
      if (first && $urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 2))
            0: return CHAR_LT;
            1: return CHAR_GT;
            default: return CHAR_SPACE;
         endcase
      end
      do
         c = 8'($urandom_range(0, 255));
      while (first ? c == CHAR_SLASH : (c == CHAR_LT || c == CHAR_GT || c == CHAR_SPACE));
      return c;
   endfunction

   function automatic int unsigned name_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 2) return NAME_MAX;
      if (roll < 5) return $urandom_range(9, NAME_MAX - 1);
      return $urandom_range(1, 6);
   endfunction

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++)
         pending_bytes.push_back(s[i]);
   endtask

   task automatic put_filler();
      logic [7:0] c;
      repeat ($urandom_range(1, 4)) begin
         do c = 8'($urandom_range(0, 255)); while (c == CHAR_LT);
         pending_bytes.push_back(c);
      end
   endtask

   // optional skipped attribute part, then the closing bracket
   task automatic end_tag(int unsigned attr_percent);
      logic [7:0] c;
      if ($urandom_range(0, 99) < attr_percent) begin
         pending_bytes.push_back(CHAR_SPACE);
         repeat ($urandom_range(0, 6)) begin
            do c = 8'($urandom_range(0, 255)); while (c == CHAR_GT);
            pending_bytes.push_back(c);
         end
      end
      pending_bytes.push_back(CHAR_GT);
   endtask

   task automatic open_tag();
      int unsigned len;
      logic [7:0] c;
      len = name_length();
      pending_bytes.push_back(CHAR_LT);
      for (int i = 0; i < len; i++) begin
         c = name_char(i == 0);
         if (gen_depth < DEPTH_MAX) gen_names[gen_depth][i] = c;
         pending_bytes.push_back(c);
      end
      end_tag(30);
      if (gen_depth < DEPTH_MAX) begin
         gen_lengths[gen_depth] = len;
         gen_depth++;
      end
   endtask

   task automatic close_tag();
      gen_depth--;
      put_text("</");
      for (int i = 0; i < gen_lengths[gen_depth]; i++)
         pending_bytes.push_back(gen_names[gen_depth][i]);
      end_tag(20);
   endtask

   task automatic report_mismatch(string field, int got, int want);
      if (mismatch_count < 40)
         $display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
      mismatch_count++;
   endtask

   // byte driver
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (pending_bytes.size() != 0 && !want_gap()) begin
            req_bus.valid <= 1'b1;
            req_bus.text_byte <= pending_bytes.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // status monitor and prediction on each byte transfer
   always @(posedge clock) begin : status_check
      status_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= !want_gap();
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_seen++;
            if (status_fifo.size() == 0) begin
               report_mismatch("unexpected result, open_depth", int'(rsp_bus.open_depth), -1);
            end else begin
               want = status_fifo.pop_front();
               if (rsp_bus.still_valid !== want.still_valid)
                  report_mismatch("still_valid", int'(rsp_bus.still_valid),
                                  int'(want.still_valid));
               if (rsp_bus.error_kind !== want.error_kind)
                  report_mismatch("error_kind", int'(rsp_bus.error_kind), int'(want.error_kind));
               if (rsp_bus.open_depth !== want.open_depth)
                  report_mismatch("open_depth", int'(rsp_bus.open_depth), int'(want.open_depth));
            end
         end
         if (req_bus.valid && req_bus.ready)
            scan_byte(req_bus.text_byte);
      end
   end

   initial begin : run
      int unsigned roll, len, pos, variant, top;
      bit climbing;
      logic [7:0] c;
      error_type closing_fault;

      // first byte of a name taken as is, skipped part holding a less-than,
      // closing names ended by a space
      put_text("<<>");
      put_text("< >");
      put_text("<a q<>");
      put_text("</a z>");
      put_text("</ >");
      put_text("</<>");

      climbing = 1'b0;
      while (pending_bytes.size() < DOC_BYTES) begin
         if (gen_depth == 0) climbing = ($urandom_range(0, 3) == 0);
         if (gen_depth == DEPTH_MAX) climbing = 1'b0;
         roll = $urandom_range(0, 99);
         if (gen_depth == DEPTH_MAX || (gen_depth > 0 && roll < (climbing ? 10 : 45)))
            close_tag();
         else if (roll < 85)
            open_tag();
         else
            put_filler();
      end

      // one sticky error ends the document
      closing_fault = error_type'($urandom_range(1, 5));
      case (closing_fault)
         ERR_MISMATCH: begin
            if (gen_depth == 0) open_tag();
            top = gen_depth - 1;
            len = gen_lengths[top];
            variant = $urandom_range(0, 2);
            pos = $urandom_range(0, len - 1);
            put_text("</");
            for (int i = 0; i < len; i++) begin
               c = gen_names[top][i];
               if (variant == 0 && i == pos) begin
                  c = c ^ 8'h01;
                  if (i != 0 && (c == CHAR_LT || c == CHAR_GT || c == CHAR_SPACE))
                     c = gen_names[top][i] ^ 8'h02;
               end
               if (!(variant == 1 && len > 1 && i == len - 1))
                  pending_bytes.push_back(c);
            end
            if (variant == 2 || (variant == 1 && len == 1)) put_text("q");
            end_tag(20);
         end
         ERR_EMPTY: begin
            while (gen_depth > 0) close_tag();
            put_text("</");
            pending_bytes.push_back(name_char(1'b1));
            repeat ($urandom_range(0, 3)) pending_bytes.push_back(name_char(1'b0));
            end_tag(20);
         end
         ERR_TOO_LONG: begin
            if ($urandom_range(0, 1)) pending_bytes.push_back(CHAR_LT);
            else put_text("</");
            pending_bytes.push_back(name_char(1'b1));
            repeat (NAME_MAX) pending_bytes.push_back(name_char(1'b0));
            pending_bytes.push_back(CHAR_GT);
         end
         ERR_OVERFLOW: begin
            while (gen_depth < DEPTH_MAX) open_tag();
            open_tag();
         end
         default: begin
            if ($urandom_range(0, 1)) pending_bytes.push_back(CHAR_LT);
            else put_text("</");
            pending_bytes.push_back(name_char(1'b1));
            repeat ($urandom_range(0, 3)) pending_bytes.push_back(name_char(1'b0));
            pending_bytes.push_back(CHAR_LT);
         end
      endcase
      repeat (16) pending_bytes.push_back(8'($urandom_range(0, 255)));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() != 0 || req_bus.valid) @(posedge clock);
      while (status_fifo.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("checked %0d results, nesting reached depth %0d", results_seen, deepest);
      $display("document ended in error %s", doc_error.name());
      if (mismatch_count == 0)
         $display("xml_tag_nesting_checker: match");
      else
         $display("xml_tag_nesting_checker: mismatch");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("xml_tag_nesting_checker: mismatch");
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/xtn_pkg.sv
src/xtn_req_if.sv
src/xtn_rsp_if.sv
src/xtn_ram.sv
src/xtn_scanner.sv
src/xml_tag_nesting_checker.sv
tb/xml_tag_nesting_checker_test.sv
